FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent holds in the cycle after antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/tssm_pkg.sv
// ----------------------------------------------------------------------------
// tssm_pkg
// Types and constants of the three-stack shared memory core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tssm_pkg;

	localparam int DATA_W  = 32;
	localparam int SEL_W   = 2;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CFG_W-1:0]  STACK_DEPTH_RESET = 11'd1024;
	localparam logic [DATA_W-1:0] EMPTY_ANSWER      = 32'hFFFF_FFFF;

	// word index of the stack_depth register
	localparam logic [PADDR_W-3:0] REG_STACK_DEPTH = 1'b0;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_PEEK  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} tssm_cmd_t;

	typedef struct packed {
		logic out_free;
	} tssm_sts_t;

endpackage

FILE: src/tssm_if.sv
// ----------------------------------------------------------------------------
// tssm_if
// Request and response channels of the three-stack core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tssm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [1:0]         stack_select;
	logic signed [31:0] push_value;

	modport source (output valid, kind, stack_select, push_value, input ready);
	modport sink (input valid, kind, stack_select, push_value, output ready);
endinterface

interface tssm_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic               stack_empty;
	logic               push_dropped;

	modport source (output valid, read_value, stack_empty, push_dropped, input ready);
	modport sink (input valid, read_value, stack_empty, push_dropped, output ready);
endinterface

FILE: src/tssm_cfg.sv
// ----------------------------------------------------------------------------
// tssm_cfg
// APB register block holding the per-stack capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssm_cfg import tssm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CFG_W-1:0]   stack_depth
);

	logic [CFG_W-1:0] stack_depth_q;
	logic             hit;

	assign hit    = (paddr[PADDR_W-1:2] == REG_STACK_DEPTH);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_depth_q <= STACK_DEPTH_RESET;
		end else if (psel && penable && pwrite && hit) begin
			stack_depth_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata      = hit ? PDATA_W'(stack_depth_q) : '0;
	assign stack_depth = stack_depth_q;

endmodule

FILE: src/tssm_ctrl.sv
// ----------------------------------------------------------------------------
// tssm_ctrl
// Sequencer: capture an item, execute it on the datapath, deliver the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tssm_ctrl import tssm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  tssm_sts_t sts,
	output tssm_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// wait until the output register can take the item
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_ready    = ready_q;
	assign cmd.capture  = req_valid && ready_q;
	assign cmd.exec     = (state_q == ST_EXEC);
	assign cmd.load_out = (state_q == ST_RESP) && sts.out_free;

	`ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec && !req_ready,
		"captured item not executed next cycle")
	`ASSERT_PROP(a_no_overlap, !(req_ready && (cmd.exec || (state_q == ST_RESP))),
		"ready while an item is in flight")

endmodule

FILE: src/tssm_dp.sv
// ----------------------------------------------------------------------------
// tssm_dp
// Datapath: shared stack memory, fill counts, result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tssm_dp import tssm_pkg::*; #(
	parameter int DEPTH      = 1024,
	parameter int NUM_STACKS = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tssm_cmd_t                cmd,
	output tssm_sts_t                sts,
	input  logic [CFG_W-1:0]         stack_depth,
	input  logic [KIND_W-1:0]        in_kind,
	input  logic [SEL_W-1:0]         in_stack_select,
	input  logic signed [DATA_W-1:0] in_push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_read_value,
	output logic                     out_stack_empty,
	output logic                     out_push_dropped
);

	localparam int WORDS  = NUM_STACKS * DEPTH;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int ID_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	// wide enough to hold NUM_STACKS itself for the range compare
	localparam int SEL_X  = ($clog2(NUM_STACKS + 1) > SEL_W) ? $clog2(NUM_STACKS + 1) : SEL_W;

	// captured item
	logic [KIND_W-1:0]        kind_q;
	logic [SEL_W-1:0]         sel_q;
	logic [DATA_W-1:0]        val_q;

	logic [CNT_W-1:0]         fill_q [NUM_STACKS];
	logic [DATA_W-1:0]        mem_q  [WORDS];
	logic [DATA_W-1:0]        rd_data_q;

	// execute-stage results
	logic                     use_mem_q;
	logic                     neg_q;
	logic                     empty_q;
	logic                     drop_q;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_value_q;
	logic                     out_empty_q;
	logic                     out_drop_q;

	kind_t                    kind;
	logic                     in_range;
	logic [ID_W-1:0]          sid;
	logic [CNT_W-1:0]         n;
	logic [CAP_W-1:0]         cap;
	logic [ADDR_W-1:0]        base;
	logic                     is_empty;
	logic                     is_full;
	logic                     do_push;
	logic                     do_read;
	logic                     do_pop;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     nxt_empty;
	logic                     nxt_drop;
	logic                     nxt_neg;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			sel_q  <= in_stack_select;
			val_q  <= in_push_value;
		end
	end

	always_comb begin
		kind     = kind_t'(kind_q);
		in_range = (SEL_X'(sel_q) < SEL_X'(NUM_STACKS));
		sid      = ID_W'(sel_q);
		n        = in_range ? fill_q[sid] : '0;
		cap      = (CAP_W'(stack_depth) > CAP_W'(DEPTH)) ? CAP_W'(DEPTH)
			: CAP_W'(stack_depth);
		base     = ADDR_W'(sid) * ADDR_W'(DEPTH);
		is_empty = (n == '0);
		is_full  = (CAP_W'(n) >= cap);
		wr_addr  = base + ADDR_W'(n);
		rd_addr  = base + ADDR_W'(n) - ADDR_W'(1);
		do_push  = in_range && (kind == KIND_PUSH) && !is_full;
		do_read  = in_range && ((kind == KIND_POP) || (kind == KIND_PEEK)) && !is_empty;
		do_pop   = do_read && (kind == KIND_POP);
		nxt_drop = (kind == KIND_PUSH) && !do_push;
		nxt_neg  = ((kind == KIND_POP) || (kind == KIND_PEEK)) && !do_read;
		if (!in_range) begin
			nxt_empty = 1'b1;
		end else if (do_push) begin
			nxt_empty = 1'b0;
		end else if (do_pop) begin
			nxt_empty = (n == CNT_W'(1));
		end else begin
			nxt_empty = is_empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.exec && in_range) begin
			if (do_push) begin
				fill_q[sid] <= n + CNT_W'(1);
			end else if (do_pop) begin
				fill_q[sid] <= n - CNT_W'(1);
			end
		end
	end

	// single-port store: a push writes, a pop or peek reads the top word
	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) begin
			mem_q[wr_addr] <= val_q;
		end
		if (cmd.exec && do_read) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			use_mem_q <= do_read;
			neg_q     <= nxt_neg;
			empty_q   <= nxt_empty;
			drop_q    <= nxt_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= use_mem_q ? rd_data_q : (neg_q ? EMPTY_ANSWER : '0);
			out_empty_q <= empty_q;
			out_drop_q  <= drop_q;
		end
	end

	assign sts.out_free     = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign out_read_value   = out_value_q;
	assign out_stack_empty  = out_empty_q;
	assign out_push_dropped = out_drop_q;

	for (genvar g = 0; g < NUM_STACKS; g++) begin : g_chk
		`ASSERT_PROP(a_fill_bound, fill_q[g] <= CNT_W'(DEPTH), "fill count above region size")
	end

	`ASSERT_NEXT(a_drop_result, cmd.load_out && drop_q,
		out_valid && out_push_dropped && (out_read_value == '0),
		"dropped push delivered with a read value")

endmodule

FILE: src/three_stacks_shared_memory_core.sv
// Result path: an accepted item passes the capture, execute and output registers in
// that order; loading the output register waits while a stalled sink holds it.
// Items do not overlap: a new item is accepted only after the previous one has left
// the capture/execute/respond sequence around the single-port stack memory.
// Reset: arst_n clears fill counts, the sequencer and the output valid; stack_depth
// returns to 1024. Memory contents are not cleared.
// ----------------------------------------------------------------------------
// three_stacks_shared_memory_core
// Three LIFO stacks sharing one memory, with an APB capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_stacks_shared_memory_core import tssm_pkg::*; #(
	parameter int DEPTH      = 1024,
	parameter int NUM_STACKS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	tssm_req_if.sink           req,
	tssm_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	tssm_cmd_t        cmd;
	tssm_sts_t        sts;
	logic [CFG_W-1:0] stack_depth;

	tssm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.stack_depth (stack_depth)
	);

	tssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tssm_dp #(
		.DEPTH      (DEPTH),
		.NUM_STACKS (NUM_STACKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.stack_depth      (stack_depth),
		.in_kind          (req.kind),
		.in_stack_select  (req.stack_select),
		.in_push_value    (req.push_value),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_read_value   (rsp.read_value),
		.out_stack_empty  (rsp.stack_empty),
		.out_push_dropped (rsp.push_dropped)
	);

endmodule
